/* design/itds_pkg.sv */
package itds_pkg;

	// fixed field widths of the channels
	localparam int VALUE_BITS_W = 32;
	localparam int LEN_W = 8;
	localparam int CHAR_W = 8;

	// default conversion width and the widest supported digit count
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int MAX_DIGITS = 20;
	localparam int DCNT_W = $clog2(MAX_DIGITS + 1);

	localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;

	typedef struct packed {
		logic [VALUE_BITS_W-1:0] value_bits;
		logic signed_mode;
		logic [LEN_W-1:0] buffer_length;
	} itds_in_t;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic last;
		logic ok;
	} itds_out_t;

	// what the front hands the back along with the bcd digits
	typedef struct packed {
		logic neg;
		logic ok;
		logic [DCNT_W-1:0] ndig;
	} itds_ctrl_t;

	// decimal digits of the largest w-bit value (1233/4096 ~ log10 2)
	function automatic int num_digits(input int w);
		return ((w * 1233) >> 12) + 1;
	endfunction

endpackage

/* design/integer_to_decimal_string.sv */
// binary to decimal text converter
// req channel: one beat carries a value, a signed/unsigned mode and the buffer
//   length; the converter answers with a run of rsp beats, one character each,
//   most significant digit first, with a leading '-' for negative signed values
//   and a NUL terminator marked last; if sign, digits and terminator do not fit
//   the buffer the run is a single NUL beat with last set and ok clear
// path: the front captures a req beat and converts it, pushes the result into
//   the queue; the back pops it and sends the characters from a register
// flow: the front takes no new req beat until the last one is converted and
//   pushed, its double-dabble unit shifting two bits per cycle; the back emits
//   one character per cycle while rsp_stall is low, after loading each run
// a two-entry queue sits between front and back so a stalled output does not
//   hold up conversion until the queue fills
// reset: all control state clears, no run is in progress, req_stall is low
// rsp_stall: the output register holds its beat; the back and then the queue
//   and the front fill up and req_stall rises
module integer_to_decimal_string #(
	parameter int VALUE_WIDTH = itds_pkg::VALUE_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  itds_pkg::itds_in_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output itds_pkg::itds_out_t rsp
);

	localparam int NDIG = itds_pkg::num_digits(VALUE_WIDTH);
	localparam int BCD_W = NDIG * 4;
	localparam int CTRL_W = $bits(itds_pkg::itds_ctrl_t);
	localparam int ENTRY_W = BCD_W + CTRL_W;

	// front to queue
	logic push;
	logic full;
	logic [BCD_W-1:0] push_digits;
	itds_pkg::itds_ctrl_t push_ctrl;

	// queue to back
	logic pop;
	logic empty;
	logic [ENTRY_W-1:0] pop_data;
	itds_pkg::itds_ctrl_t pop_ctrl;
	logic [BCD_W-1:0] pop_digits;

	assign pop_ctrl = pop_data[ENTRY_W-1:BCD_W];
	assign pop_digits = pop_data[BCD_W-1:0];

	// sign handling, bcd conversion, digit count and buffer check
	itds_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.push(push),
		.push_digits(push_digits),
		.push_ctrl(push_ctrl),
		.full(full)
	);

	// classified conversions waiting for the serializer
	itds_queue #(
		.WIDTH(ENTRY_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data({push_ctrl, push_digits}),
		.full(full),
		.pop(pop),
		.pop_data(pop_data),
		.empty(empty)
	);

	// character serializer with registered output
	itds_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.pop(pop),
		.pop_digits(pop_digits),
		.pop_ctrl(pop_ctrl),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

endmodule

/* design/itds_front.sv */
module itds_front #(
	parameter int VALUE_WIDTH = itds_pkg::VALUE_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  itds_pkg::itds_in_t req,
	output logic push,
	output logic [itds_pkg::num_digits(VALUE_WIDTH)*4-1:0] push_digits,
	output itds_pkg::itds_ctrl_t push_ctrl,
	input  logic full
);

	localparam int NDIG = itds_pkg::num_digits(VALUE_WIDTH);
	localparam int BCD_W = NDIG * 4;
	localparam int MAG_W = VALUE_WIDTH + (VALUE_WIDTH % 2);
	localparam int STEPS = MAG_W / 2;
	localparam int STEP_W = $clog2(STEPS);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_CONV = 3'b010,
		F_PUSH = 3'b100
	} itds_fstate_t;

	itds_fstate_t state_q;
	logic [STEP_W-1:0] step_q;
	logic [MAG_W-1:0] mag_q;
	logic [BCD_W-1:0] bcd_q;
	logic neg_q;
	logic [itds_pkg::LEN_W-1:0] len_q;

	logic [VALUE_WIDTH-1:0] val;
	logic [VALUE_WIDTH-1:0] mag;
	logic neg;
	logic [MAG_W-1:0] mag_n;
	logic [BCD_W-1:0] bcd_n;
	logic [itds_pkg::DCNT_W-1:0] nd;
	logic [itds_pkg::LEN_W-1:0] needed;
	logic fits;

	generate
		if (VALUE_WIDTH <= itds_pkg::VALUE_BITS_W) begin : g_trunc
			assign val = req.value_bits[VALUE_WIDTH-1:0];
		end else begin : g_ext
			assign val = {{(VALUE_WIDTH - itds_pkg::VALUE_BITS_W){1'b0}}, req.value_bits};
		end
	endgenerate

	// magnitude; the most negative value negates to itself, read unsigned
	assign neg = req.signed_mode & val[VALUE_WIDTH-1];
	assign mag = neg ? (~val + 1'b1) : val;

	// two shift-add-3 steps per cycle
	always_comb begin
		bcd_n = bcd_q;
		mag_n = mag_q;
		for (int s = 0; s < 2; s++) begin
			for (int d = 0; d < NDIG; d++) begin
				if (bcd_n[d*4 +: 4] >= 4'd5) begin
					bcd_n[d*4 +: 4] = bcd_n[d*4 +: 4] + 4'd3;
				end
			end
			bcd_n = {bcd_n[BCD_W-2:0], mag_n[MAG_W-1]};
			mag_n = {mag_n[MAG_W-2:0], 1'b0};
		end
	end

	// digit count from the highest nonzero digit, zero counts as one digit
	always_comb begin
		nd = itds_pkg::DCNT_W'(1);
		for (int d = 1; d < NDIG; d++) begin
			if (bcd_q[d*4 +: 4] != 4'd0) begin
				nd = itds_pkg::DCNT_W'(d + 1);
			end
		end
	end

	assign needed = itds_pkg::LEN_W'(nd) + itds_pkg::LEN_W'(neg_q) + itds_pkg::LEN_W'(1);
	assign fits = (len_q >= needed);

	assign req_stall = (state_q != F_IDLE);
	assign push = (state_q == F_PUSH) && !full;
	assign push_digits = bcd_q;
	assign push_ctrl = '{neg: neg_q, ok: fits, ndig: nd};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (req_valid) begin
						state_q <= F_CONV;
						step_q <= '0;
					end
				end
				F_CONV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(STEPS - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && req_valid) begin
			mag_q <= MAG_W'(mag);
			bcd_q <= '0;
			neg_q <= neg;
			len_q <= req.buffer_length;
		end else if (state_q == F_CONV) begin
			mag_q <= mag_n;
			bcd_q <= bcd_n;
		end
	end

endmodule

/* design/itds_queue.sv */
module itds_queue #(
	parameter int WIDTH = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [WIDTH-1:0] push_data,
	output logic full,
	input  logic pop,
	output logic [WIDTH-1:0] pop_data,
	output logic empty
);

	// two entries
	logic [WIDTH-1:0] mem_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

/* design/itds_back.sv */
module itds_back #(
	parameter int VALUE_WIDTH = itds_pkg::VALUE_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic empty,
	output logic pop,
	input  logic [itds_pkg::num_digits(VALUE_WIDTH)*4-1:0] pop_digits,
	input  itds_pkg::itds_ctrl_t pop_ctrl,
	output logic rsp_valid,
	input  logic rsp_stall,
	output itds_pkg::itds_out_t rsp
);

	localparam int NDIG = itds_pkg::num_digits(VALUE_WIDTH);
	localparam int BCD_W = NDIG * 4;
	localparam int IDX_W = $clog2(NDIG);

	typedef enum logic [4:0] {
		B_IDLE  = 5'b00001,
		B_SIGN  = 5'b00010,
		B_DIGIT = 5'b00100,
		B_TERM  = 5'b01000,
		B_FAIL  = 5'b10000
	} itds_bstate_t;

	itds_bstate_t state_q;
	logic [IDX_W-1:0] idx_q;
	logic [BCD_W-1:0] dig_q;
	logic rsp_valid_q;
	itds_pkg::itds_out_t rsp_q;

	logic advance;
	itds_pkg::itds_out_t rsp_n;
	logic [itds_pkg::DCNT_W-1:0] top_idx;

	assign advance = !rsp_valid_q || !rsp_stall;
	assign pop = (state_q == B_IDLE) && !empty;
	assign top_idx = pop_ctrl.ndig - 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		unique case (state_q)
			B_SIGN:  rsp_n = '{character: itds_pkg::CH_MINUS, last: 1'b0, ok: 1'b1};
			B_DIGIT: rsp_n = '{character: itds_pkg::CH_ZERO + {4'h0, dig_q[idx_q*4 +: 4]},
				last: 1'b0, ok: 1'b1};
			B_TERM:  rsp_n = '{character: itds_pkg::CH_NUL, last: 1'b1, ok: 1'b1};
			B_FAIL:  rsp_n = '{character: itds_pkg::CH_NUL, last: 1'b1, ok: 1'b0};
			default: rsp_n = '{character: itds_pkg::CH_NUL, last: 1'b0, ok: 1'b0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			idx_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				rsp_valid_q <= (state_q != B_IDLE);
			end
			unique case (state_q)
				B_IDLE: begin
					if (!empty) begin
						idx_q <= IDX_W'(top_idx);
						if (!pop_ctrl.ok) begin
							state_q <= B_FAIL;
						end else if (pop_ctrl.neg) begin
							state_q <= B_SIGN;
						end else begin
							state_q <= B_DIGIT;
						end
					end
				end
				B_SIGN: begin
					if (advance) begin
						state_q <= B_DIGIT;
					end
				end
				B_DIGIT: begin
					if (advance) begin
						if (idx_q == '0) begin
							state_q <= B_TERM;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				B_TERM, B_FAIL: begin
					if (advance) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dig_q <= pop_digits;
		end
		if (advance) begin
			rsp_q <= rsp_n;
		end
	end

endmodule
